// File: design/pcp_pkg.sv
// Shared constants and types for the point camera projection and crop block.
package pcp_pkg;

  // Fixed field widths of the stream and configuration ports.
  localparam int unsigned CoefW    = 32;
  localparam int unsigned PointW   = 32;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned DimRegW  = 13;
  localparam int unsigned PixW     = 12;
  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 32;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROW0_XY = 3'd0,
    CFG_ROW0_ZT = 3'd1,
    CFG_ROW1_XY = 3'd2,
    CFG_ROW1_ZT = 3'd3,
    CFG_ROW2_XY = 3'd4,
    CFG_ROW2_ZT = 3'd5,
    CFG_WIDTH   = 3'd6,
    CFG_HEIGHT  = 3'd7
  } cfg_idx_e;

endpackage

// File: design/pcp_row.sv
// One matrix row dot product: products, floored pair sums, final sum in three stages.
module pcp_row import pcp_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned SUM_W     = 2 * CoefW - FRAC_BITS + 2
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [CfgDataW-1:0]     coef_xy_i,
  input  logic [CfgDataW-1:0]     coef_zt_i,
  input  logic signed [PointW-1:0] x_i,
  input  logic signed [PointW-1:0] y_i,
  input  logic signed [PointW-1:0] z_i,
  output logic signed [SUM_W-1:0] sum_o
);

  localparam int unsigned ProdW = CoefW + PointW;
  localparam int unsigned ShW   = ProdW - FRAC_BITS;

  logic signed [ProdW-1:0] prod_x_q, prod_y_q, prod_z_q;
  logic signed [CoefW-1:0] trans_q;
  logic signed [ShW-1:0]   sh_x, sh_y, sh_z;
  logic signed [SUM_W-1:0] pair_a_q, pair_b_q, sum_q;

  // Stage 1: the three exact coefficient times coordinate products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_x_q <= $signed(coef_xy_i[CoefW-1:0]) * x_i;
      prod_y_q <= $signed(coef_xy_i[2*CoefW-1:CoefW]) * y_i;
      prod_z_q <= $signed(coef_zt_i[CoefW-1:0]) * z_i;
      trans_q  <= $signed(coef_zt_i[2*CoefW-1:CoefW]);
    end
  end

  // Dropping the low fraction bits of a two's complement value floors it.
  assign sh_x = prod_x_q[ProdW-1:FRAC_BITS];
  assign sh_y = prod_y_q[ProdW-1:FRAC_BITS];
  assign sh_z = prod_z_q[ProdW-1:FRAC_BITS];

  // Stage 2: two pair sums.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pair_a_q <= SUM_W'(sh_x) + SUM_W'(sh_y);
      pair_b_q <= SUM_W'(sh_z) + SUM_W'(trans_q);
    end
  end

  // Stage 3: the row sum.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= pair_a_q + pair_b_q;
    end
  end

  assign sum_o = sum_q;

endmodule

// File: design/pcp_div.sv
// Pipelined restoring divider, one quotient bit per stage, with an overflow flag.
module pcp_div import pcp_pkg::*; #(
  parameter int unsigned MAG_W = 50,
  parameter int unsigned QB    = 12
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [MAG_W-1:0] num_i,
  input  logic [MAG_W-1:0] den_i,
  output logic [QB-1:0]    quot_o,
  output logic             ovf_o
);

  localparam int unsigned CmpW = MAG_W + QB;

  logic [MAG_W-1:0] rem_in  [QB];
  logic [MAG_W-1:0] den_in  [QB];
  logic [QB-1:0]    quot_in [QB];
  logic             ovf_in  [QB];
  logic [MAG_W-1:0] rem_q   [QB];
  logic [MAG_W-1:0] den_q   [QB];
  logic [QB-1:0]    quot_q  [QB];
  logic             ovf_q   [QB];

  // The quotient does not fit in QB bits when num >= den * 2^QB.
  assign rem_in[0]  = num_i;
  assign den_in[0]  = den_i;
  assign quot_in[0] = '0;
  assign ovf_in[0]  = CmpW'(num_i) >= (CmpW'(den_i) << QB);

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int unsigned Bit = QB - 1 - k;
    logic [CmpW-1:0] dsh;
    logic            take;

    if (k > 0) begin : g_link
      assign rem_in[k]  = rem_q[k-1];
      assign den_in[k]  = den_q[k-1];
      assign quot_in[k] = quot_q[k-1];
      assign ovf_in[k]  = ovf_q[k-1];
    end

    // Trial subtraction of the shifted divisor for this quotient bit.
    assign dsh  = CmpW'(den_in[k]) << Bit;
    assign take = CmpW'(rem_in[k]) >= dsh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? MAG_W'(CmpW'(rem_in[k]) - dsh) : rem_in[k];
        den_q[k]  <= den_in[k];
        quot_q[k] <= quot_in[k] | (QB'(take) << Bit);
        ovf_q[k]  <= ovf_in[k];
      end
    end
  end

  assign quot_o = quot_q[QB-1];
  assign ovf_o  = ovf_q[QB-1];

endmodule

// File: design/point_camera_projection_crop_top.sv
// Each point passes the dot product stages, the sign stage, the quotient stages and the output register.
// Throughput: one point per cycle; the pipeline advances as a whole whenever the
// output register is empty or its result is being taken.
// The quotient pipeline retires one bit per stage, which sets the latency.
// Reset clears the stage valid bits and loads the registers to their defaults
// (zero matrix, 1920 by 1080 image).
module point_camera_projection_crop_top import pcp_pkg::*; #(
  parameter int unsigned IMG_DIM_MAX = 4096,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: point_x [31:0], point_y [63:32], point_z [95:64]
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: inside_res [0], pixel_column [12:1], pixel_row [24:13], zeros above
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned SumW  = 2 * CoefW - FRAC_BITS + 2;
  localparam int unsigned MagW  = SumW;
  localparam int unsigned QB    = $clog2(IMG_DIM_MAX);
  localparam int unsigned DimW  = $clog2(IMG_DIM_MAX + 1);
  localparam int unsigned CmpW  = (DimW > DimRegW) ? DimW : DimRegW;
  localparam int unsigned Lat   = 3 + 1 + QB + 1;

  logic [CfgDataW-1:0] coef_q [6];
  logic [DimRegW-1:0]  width_q, height_q;
  logic [CmpW-1:0]     dim_w, dim_h;
  logic                en;
  logic [Lat-1:0]      vld_q;
  logic [2:0]          xpos_q;
  logic signed [PointW-1:0] pt_x, pt_y, pt_z;
  logic signed [SumW-1:0]   sum_u, sum_v, sum_w;
  logic signed [SumW:0]     sgn_u, sgn_v, sgn_w;
  logic                     ok_d;
  logic [MagW-1:0]  mag_u_q, mag_v_q, mag_w_q;
  logic             ok_q;
  logic [QB-1:0]    ok_pipe_q;
  logic [QB-1:0]    quot_u, quot_v;
  logic             ovf_u, ovf_v;
  logic             inside_d;
  logic             inside_q;
  logic [PixW-1:0]  col_q, row_q;

  // Configuration writes; indexes cover the whole register list.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) coef_q[i] <= '0;
      width_q  <= DimRegW'(1920);
      height_q <= DimRegW'(1080);
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ROW0_XY: coef_q[0] <= cfg_data_i;
        CFG_ROW0_ZT: coef_q[1] <= cfg_data_i;
        CFG_ROW1_XY: coef_q[2] <= cfg_data_i;
        CFG_ROW1_ZT: coef_q[3] <= cfg_data_i;
        CFG_ROW2_XY: coef_q[4] <= cfg_data_i;
        CFG_ROW2_ZT: coef_q[5] <= cfg_data_i;
        CFG_WIDTH:   width_q   <= cfg_data_i[DimRegW-1:0];
        CFG_HEIGHT:  height_q  <= cfg_data_i[DimRegW-1:0];
        default: ;
      endcase
    end
  end

  // Image dimensions saturate at the largest supported size.
  assign dim_w = (CmpW'(width_q) > CmpW'(IMG_DIM_MAX)) ? CmpW'(IMG_DIM_MAX) : CmpW'(width_q);
  assign dim_h = (CmpW'(height_q) > CmpW'(IMG_DIM_MAX)) ? CmpW'(IMG_DIM_MAX)
                                                         : CmpW'(height_q);

  // The whole pipeline moves together; valid bits travel with the data.
  assign en            = !vld_q[Lat-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
    end
  end

  assign pt_x = $signed(s_axis_tdata[PointW-1:0]);
  assign pt_y = $signed(s_axis_tdata[2*PointW-1:PointW]);
  assign pt_z = $signed(s_axis_tdata[3*PointW-1:2*PointW]);

  // Forward-facing flag follows the three dot product stages.
  always_ff @(posedge clk_i) begin
    if (en) begin
      xpos_q <= {xpos_q[1:0], !pt_x[PointW-1]};
    end
  end

  pcp_row #(.FRAC_BITS(FRAC_BITS), .SUM_W(SumW)) u_row_u (
    .clk_i, .en_i(en), .coef_xy_i(coef_q[0]), .coef_zt_i(coef_q[1]),
    .x_i(pt_x), .y_i(pt_y), .z_i(pt_z), .sum_o(sum_u)
  );
  pcp_row #(.FRAC_BITS(FRAC_BITS), .SUM_W(SumW)) u_row_v (
    .clk_i, .en_i(en), .coef_xy_i(coef_q[2]), .coef_zt_i(coef_q[3]),
    .x_i(pt_x), .y_i(pt_y), .z_i(pt_z), .sum_o(sum_v)
  );
  pcp_row #(.FRAC_BITS(FRAC_BITS), .SUM_W(SumW)) u_row_w (
    .clk_i, .en_i(en), .coef_xy_i(coef_q[4]), .coef_zt_i(coef_q[5]),
    .x_i(pt_x), .y_i(pt_y), .z_i(pt_z), .sum_o(sum_w)
  );

  // Sign stage: flip all three sums for a negative divisor, then reject
  // behind points, a zero divisor and negative numerators.
  always_comb begin
    sgn_u = (SumW+1)'(sum_u);
    sgn_v = (SumW+1)'(sum_v);
    sgn_w = (SumW+1)'(sum_w);
    if (sum_w[SumW-1]) begin
      sgn_u = -sgn_u;
      sgn_v = -sgn_v;
      sgn_w = -sgn_w;
    end
    ok_d = xpos_q[2] && (sum_w != '0) && !sgn_u[SumW] && !sgn_v[SumW];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_u_q <= sgn_u[MagW-1:0];
      mag_v_q <= sgn_v[MagW-1:0];
      mag_w_q <= sgn_w[MagW-1:0];
      ok_q    <= ok_d;
    end
  end

  pcp_div #(.MAG_W(MagW), .QB(QB)) u_div_col (
    .clk_i, .en_i(en), .num_i(mag_u_q), .den_i(mag_w_q), .quot_o(quot_u), .ovf_o(ovf_u)
  );
  pcp_div #(.MAG_W(MagW), .QB(QB)) u_div_row (
    .clk_i, .en_i(en), .num_i(mag_v_q), .den_i(mag_w_q), .quot_o(quot_v), .ovf_o(ovf_v)
  );

  // Acceptance flag keeps pace with the quotient stages.
  always_ff @(posedge clk_i) begin
    if (en) begin
      ok_pipe_q <= {ok_pipe_q[QB-2:0], ok_q};
    end
  end

  // Output stage: crop against the image and zero rejected points.
  assign inside_d = ok_pipe_q[QB-1] && !ovf_u && !ovf_v &&
                    (CmpW'(quot_u) < dim_w) && (CmpW'(quot_v) < dim_h);

  always_ff @(posedge clk_i) begin
    if (en) begin
      inside_q <= inside_d;
      col_q    <= inside_d ? PixW'(quot_u) : '0;
      row_q    <= inside_d ? PixW'(quot_v) : '0;
    end
  end

  assign m_axis_tdata = OutDataW'({row_q, col_q, inside_q});

  // A rejected point carries zero coordinates.
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[24:1] == '0))
    else $error("rejected point has nonzero pixel coordinates");

  // A kept point lies within the cropped image.
  a_inside_crop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0]) |->
      ((CmpW'(m_axis_tdata[12:1]) < dim_w) && (CmpW'(m_axis_tdata[24:13]) < dim_h)))
    else $error("kept point lies outside the image");

  // The input side only stalls while a finished result waits.
  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a waiting result");

endmodule
